// ===== design/xpfec_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xpfec_pkg
// Shared types and constants for the XOR pair parity FEC sender.
// ----------------------------------------------------------------------------
package xpfec_pkg;

    localparam int WORD_W = 32;
    localparam int LEN_W  = 12;

    // Flag set in the sequence word to form a parity header
    localparam logic [WORD_W-1:0] PARITY_FLAG = 32'h8000_0000;

    // Controller states
    typedef enum logic [1:0] {
        ST_RUN,
        ST_PAR_HDR,
        ST_PAR_DAT
    } ctrl_state_t;

    // Source of the output register load
    typedef enum logic [1:0] {
        SRC_PASS,
        SRC_HDR,
        SRC_PAR
    } out_src_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic     load;      // load output register
        out_src_t src;       // what to load
        logic     last;      // tlast of the loaded beat
        logic     we0;       // write bank 0
        logic     we1;       // write bank 1
        logic     re;        // read both banks
        logic     seq_load;  // capture sequence word
    } ctl_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic out_free;      // output register can take a beat this cycle
        logic seq_odd;       // captured sequence is odd
    } ctl_stat_t;

endpackage

// ===== design/xpfec_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xpfec_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module xpfec_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 40,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/xpfec_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xpfec_datapath
// Payload banks, sequence register and output register of the FEC sender.
// ----------------------------------------------------------------------------
module xpfec_datapath
    import xpfec_pkg::*;
#(
    parameter int PAYLOAD_WORDS = 40,
    parameter int ADDR_W        = (PAYLOAD_WORDS > 1) ? $clog2(PAYLOAD_WORDS) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  ctl_cmd_t          cmd,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [ADDR_W-1:0] raddr,
    input  logic [WORD_W-1:0] in_word,
    input  logic              out_ready,
    output ctl_stat_t         stat,
    output logic              out_valid,
    output logic [WORD_W-1:0] out_word,
    output logic              out_kind,
    output logic              out_last
);

    logic [WORD_W-1:0] rdata0;
    logic [WORD_W-1:0] rdata1;
    logic [WORD_W-1:0] seq_reg;
    logic              valid_reg;
    logic              valid_next;
    logic [WORD_W-1:0] word_reg;
    logic              kind_reg;
    logic              last_reg;
    logic [WORD_W-1:0] load_word;

    // Two payload banks; one holds the previous packet, the other the current
    xpfec_ram #(
        .WIDTH (WORD_W),
        .DEPTH (PAYLOAD_WORDS),
        .ADDR_W(ADDR_W)
    ) u_bank0 (
        .clk  (clk),
        .we   (cmd.we0),
        .waddr(waddr),
        .wdata(in_word),
        .re   (cmd.re),
        .raddr(raddr),
        .rdata(rdata0)
    );

    xpfec_ram #(
        .WIDTH (WORD_W),
        .DEPTH (PAYLOAD_WORDS),
        .ADDR_W(ADDR_W)
    ) u_bank1 (
        .clk  (clk),
        .we   (cmd.we1),
        .waddr(waddr),
        .wdata(in_word),
        .re   (cmd.re),
        .raddr(raddr),
        .rdata(rdata1)
    );

    // Sequence word of the kept datagram
    always_ff @(posedge clk)
    begin
        if (cmd.seq_load)
        begin
            seq_reg <= in_word;
        end
    end

    // Output beat source select
    always_comb
    begin
        case (cmd.src)
            SRC_PASS: load_word = in_word;
            SRC_HDR:  load_word = seq_reg | PARITY_FLAG;
            SRC_PAR:  load_word = rdata0 ^ rdata1;
            default:  load_word = in_word;
        endcase
    end

    // Output register
    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            word_reg <= load_word;
            kind_reg <= (cmd.src != SRC_PASS);
            last_reg <= cmd.last;
        end
    end

    assign stat.out_free = !valid_reg || out_ready;
    assign stat.seq_odd  = seq_reg[0];

    assign out_valid = valid_reg;
    assign out_word  = word_reg;
    assign out_kind  = kind_reg;
    assign out_last  = last_reg;

endmodule

// ===== design/xpfec_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xpfec_ctrl
// Controller: datagram tracking, bank swap and parity burst sequencing.
// ----------------------------------------------------------------------------
module xpfec_ctrl
    import xpfec_pkg::*;
#(
    parameter int PAYLOAD_WORDS = 40,
    parameter int ADDR_W        = (PAYLOAD_WORDS > 1) ? $clog2(PAYLOAD_WORDS) : 1,
    parameter int CNT_W         = $clog2(PAYLOAD_WORDS + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_first,
    input  logic [LEN_W-1:0]  in_len,
    input  ctl_stat_t         stat,
    output logic              in_ready,
    output ctl_cmd_t          cmd,
    output logic [ADDR_W-1:0] waddr,
    output logic [ADDR_W-1:0] raddr
);

    localparam logic [LEN_W-1:0]  MIN_BYTES = LEN_W'(4 + 4 * PAYLOAD_WORDS);
    localparam logic [CNT_W-1:0]  IDX_LAST  = CNT_W'(PAYLOAD_WORDS);
    localparam logic [ADDR_W-1:0] PAR_LAST  = ADDR_W'(PAYLOAD_WORDS - 1);

    ctrl_state_t       state_reg, state_next;
    logic              keep_reg, keep_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              have_prev_reg, have_prev_next;
    logic              sel_reg, sel_next;
    logic [ADDR_W-1:0] pcnt_reg, pcnt_next;
    logic              accept;
    logic              done;
    logic              wr;

    assign in_ready = (state_reg == ST_RUN) && stat.out_free;
    assign accept   = in_valid && in_ready;
    assign done     = (idx_reg == IDX_LAST);
    assign waddr    = ADDR_W'(idx_reg - 1'b1);

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            keep_reg      <= 1'b0;
            idx_reg       <= '0;
            have_prev_reg <= 1'b0;
            sel_reg       <= 1'b0;
            pcnt_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            keep_reg      <= keep_next;
            idx_reg       <= idx_next;
            have_prev_reg <= have_prev_next;
            sel_reg       <= sel_next;
            pcnt_reg      <= pcnt_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        keep_next      = keep_reg;
        idx_next       = idx_reg;
        have_prev_next = have_prev_reg;
        sel_next       = sel_reg;
        pcnt_next      = pcnt_reg;
        cmd            = '0;
        cmd.src        = SRC_PASS;
        raddr          = pcnt_reg;
        wr             = 1'b0;

        unique case (state_reg)
            ST_RUN:
            begin
                if (accept && in_first)
                begin
                    // new datagram: keep it only if long enough
                    keep_next = (in_len >= MIN_BYTES);
                    idx_next  = '0;
                    if (in_len >= MIN_BYTES)
                    begin
                        cmd.seq_load = 1'b1;
                        cmd.load     = 1'b1;
                        idx_next     = CNT_W'(1);
                    end
                end
                else if (accept && keep_reg && (idx_reg != '0) && (idx_reg <= IDX_LAST))
                begin
                    // payload beat: forward and store in the current bank
                    wr       = 1'b1;
                    cmd.load = 1'b1;
                    cmd.last = done;
                    idx_next = CNT_W'(idx_reg + 1'b1);
                    if (done)
                    begin
                        keep_next      = 1'b0;
                        idx_next       = '0;
                        sel_next       = !sel_reg;
                        have_prev_next = 1'b1;
                        if (stat.seq_odd && have_prev_reg)
                        begin
                            state_next = ST_PAR_HDR;
                        end
                    end
                end
            end

            ST_PAR_HDR:
            begin
                if (stat.out_free)
                begin
                    cmd.load   = 1'b1;
                    cmd.src    = SRC_HDR;
                    cmd.re     = 1'b1;
                    raddr      = '0;
                    pcnt_next  = '0;
                    state_next = ST_PAR_DAT;
                end
            end

            ST_PAR_DAT:
            begin
                if (stat.out_free)
                begin
                    cmd.load = 1'b1;
                    cmd.src  = SRC_PAR;
                    cmd.last = (pcnt_reg == PAR_LAST);
                    if (pcnt_reg == PAR_LAST)
                    begin
                        state_next = ST_RUN;
                    end
                    else
                    begin
                        // fetch the next word while this one goes out
                        cmd.re    = 1'b1;
                        raddr     = ADDR_W'(pcnt_reg + 1'b1);
                        pcnt_next = ADDR_W'(pcnt_reg + 1'b1);
                    end
                end
            end

            default:
            begin
                state_next = ST_RUN;
            end
        endcase

        cmd.we0 = wr && !sel_reg;
        cmd.we1 = wr && sel_reg;
    end

endmodule

// ===== design/xor_pair_parity_fec_sender.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xor_pair_parity_fec_sender
// XOR pair parity FEC sender: forwards datagram packets, adds parity packets.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side takes datagram words, one beat per word; tuser marks the first
//   (sequence) word, which also carries the byte length in tdata. Datagrams
//   shorter than 4 + 4*PAYLOAD_WORDS bytes are dropped; of kept ones the
//   sequence word and PAYLOAD_WORDS payload words go out on the master side
//   with tuser = 0, the last payload word with tlast. Extra words are eaten.
//   After an odd-sequence packet, with an earlier complete packet stored, a
//   parity packet follows (tuser = 1): header = sequence | 0x80000000, then
//   PAYLOAD_WORDS words of current XOR previous payload, tlast on the last.
//   A taken input beat is registered and goes out from the next cycle.
//   Input runs at one beat per cycle while the master side is ready; a parity
//   burst goes out one beat a cycle while the master side is ready, set by the
//   single output register and the bank read port, and holds off the slave side.
//   A master-side stall holds the output register and s_tready drops in the
//   same cycle. Reset empties the output register and forgets any stored
//   packet; the payload banks need no clearing.
// ----------------------------------------------------------------------------
module xor_pair_parity_fec_sender
    import xpfec_pkg::*;
#(
    parameter int PAYLOAD_WORDS = 40
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [31:0] word, [43:32] byte_length, [47:44] zero
    input  logic [0:0]  s_tuser,   // [0] first
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] out_word
    output logic [0:0]  m_tuser,   // [0] kind
    output logic        m_tlast
);

    localparam int ADDR_W = (PAYLOAD_WORDS > 1) ? $clog2(PAYLOAD_WORDS) : 1;

    ctl_cmd_t          cmd;
    ctl_stat_t         stat;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;
    logic              kind;

    xpfec_ctrl #(
        .PAYLOAD_WORDS(PAYLOAD_WORDS),
        .ADDR_W       (ADDR_W)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(s_tvalid),
        .in_first(s_tuser[0]),
        .in_len  (s_tdata[43:32]),
        .stat    (stat),
        .in_ready(s_tready),
        .cmd     (cmd),
        .waddr   (waddr),
        .raddr   (raddr)
    );

    xpfec_datapath #(
        .PAYLOAD_WORDS(PAYLOAD_WORDS),
        .ADDR_W       (ADDR_W)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .waddr    (waddr),
        .raddr    (raddr),
        .in_word  (s_tdata[31:0]),
        .out_ready(m_tready),
        .stat     (stat),
        .out_valid(m_tvalid),
        .out_word (m_tdata),
        .out_kind (kind),
        .out_last (m_tlast)
    );

    assign m_tuser[0] = kind;

endmodule

// ===== design/xpfec_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xpfec_checker
// Port-level checks of the FEC sender, bound to the top level.
// ----------------------------------------------------------------------------
module xpfec_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [0:0]  m_tuser,
    input logic        m_tlast
);

    // stalled beat stays valid
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
    else $error("m_tvalid dropped during stall");

    // stalled beat holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
    else $error("master payload changed during stall");

    // no input taken while the output register is blocked
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
    else $error("s_tready high while output stalled");

    // input held off while a parity beat other than the last is in the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] && !m_tlast |-> !s_tready)
    else $error("s_tready high inside parity burst");

endmodule

bind xor_pair_parity_fec_sender xpfec_checker u_xpfec_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
);

// ===== test/xor_pair_parity_fec_sender_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xor_pair_parity_fec_sender_checker
// Watches both stream ports of the parity sender, predicts each outgoing beat
// from the accepted input beats and compares them field by field, in order.
// ----------------------------------------------------------------------------
module xor_pair_parity_fec_sender_checker
    import xpfec_pkg::*;
#(
    parameter int PAYLOAD_WORDS = 40
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,   // [31:0] word, [43:32] byte_length, [47:44] zero
    input  logic [0:0]  s_tuser,   // [0] first
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // [31:0] out_word
    input  logic [0:0]  m_tuser,   // [0] kind
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending
);

    localparam int MIN_BYTES = 4 + 4 * PAYLOAD_WORDS;

    // Packet kind carried in tuser
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_PARITY = 1'b1;

    typedef struct {
        logic [WORD_W-1:0] word;
        logic              kind;
        logic              last;
    } out_beat_t;

    out_beat_t         outgoing_beats[$];
    logic [WORD_W-1:0] stored_payload[PAYLOAD_WORDS];
    logic [WORD_W-1:0] xor_payload[PAYLOAD_WORDS];
    logic              prev_valid;
    logic              in_packet;
    int                word_pos;
    logic [WORD_W-1:0] seq_word;
    int                beat_count;

    initial
    begin
        fail_count = 0;
        pending    = 0;
        beat_count = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch at out beat %0d: %s", $time, beat_count, msg);
        fail_count++;
    endtask

    task automatic queue_beat(input logic [WORD_W-1:0] w, input logic k, input logic l);
        out_beat_t b;
        b.word = w;
        b.kind = k;
        b.last = l;
        outgoing_beats.push_back(b);
    endtask

    // Advance the sender state by one input beat and queue the beats it emits
    task automatic predict_packet_beats(input logic [WORD_W-1:0] w, input logic is_first,
                                        input logic [LEN_W-1:0] len);
        int  p;
        logic done;
        if (is_first)
        begin
            in_packet = (len >= MIN_BYTES);
            word_pos  = 0;
            if (in_packet)
            begin
                seq_word = w;
                queue_beat(w, KIND_DATA, 1'b0);
                word_pos = 1;
            end
        end
        else if (in_packet && word_pos >= 1 && word_pos <= PAYLOAD_WORDS)
        begin
            p = word_pos - 1;
            xor_payload[p] = w ^ (prev_valid ? stored_payload[p] : '0);
            done = (word_pos == PAYLOAD_WORDS);
            queue_beat(w, KIND_DATA, done);
            if (!done)
            begin
                word_pos++;
            end
            else
            begin
                // odd sequence with a stored packet closes a pair
                if (seq_word[0] && prev_valid)
                begin
                    queue_beat(seq_word | PARITY_FLAG, KIND_PARITY, 1'b0);
                    for (int i = 0; i < PAYLOAD_WORDS; i++)
                        queue_beat(xor_payload[i], KIND_PARITY, i == PAYLOAD_WORDS - 1);
                end
                // recover the plain payload for the next pair
                for (int i = 0; i < PAYLOAD_WORDS; i++)
                    stored_payload[i] = xor_payload[i] ^ (prev_valid ? stored_payload[i] : '0);
                prev_valid = 1'b1;
                in_packet  = 1'b0;
                word_pos   = 0;
            end
        end
    endtask

    // Predict on input beats, then compare output beats against the oldest entry
    always @(posedge clk or negedge rst_n)
    begin
        out_beat_t want;
        if (!rst_n)
        begin
            prev_valid = 1'b0;
            in_packet  = 1'b0;
            word_pos   = 0;
            seq_word   = '0;
            outgoing_beats.delete();
            pending    = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                predict_packet_beats(s_tdata[31:0], s_tuser[0], s_tdata[43:32]);
            if (m_tvalid && m_tready)
            begin
                if (outgoing_beats.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected beat word=%h kind=%0d last=%0d",
                                              m_tdata, m_tuser[0], m_tlast));
                end
                else
                begin
                    want = outgoing_beats.pop_front();
                    if (m_tdata !== want.word)
                        report_mismatch($sformatf("word %h, want %h", m_tdata, want.word));
                    if (m_tuser[0] !== want.kind)
                        report_mismatch($sformatf("kind %0d, want %0d", m_tuser[0], want.kind));
                    if (m_tlast !== want.last)
                        report_mismatch($sformatf("last %0d, want %0d", m_tlast, want.last));
                end
                beat_count++;
            end
            pending = outgoing_beats.size();
        end
    end

endmodule

// ===== test/xor_pair_parity_fec_sender_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xor_pair_parity_fec_sender_tb
// Drives datagrams into the parity sender: a few directed edge cases, then
// random kept, cut, dropped and stray beats with random idling on both ports
// and one long output stall. The checker module judges every output beat.
// ----------------------------------------------------------------------------
module xor_pair_parity_fec_sender_tb;
    import xpfec_pkg::*;

    localparam int PAYLOAD_WORDS = 40;
    localparam int MIN_BYTES     = 4 + 4 * PAYLOAD_WORDS;
    localparam int KEPT_TARGET   = 480;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;    // [31:0] word, [43:32] byte_length, [47:44] zero
    logic [0:0]  s_tuser  = '0;    // [0] first
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;          // [31:0] out_word
    logic [0:0]  m_tuser;          // [0] kind
    logic        m_tlast;

    int   fail_count;
    int   pending;
    int   kept_beats  = 0;
    logic src_steady  = 1'b0;
    logic sink_steady = 1'b0;
    logic hold_req    = 1'b0;
    logic hold_issued = 1'b0;

    xor_pair_parity_fec_sender #(
        .PAYLOAD_WORDS (PAYLOAD_WORDS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    xor_pair_parity_fec_sender_checker #(
        .PAYLOAD_WORDS (PAYLOAD_WORDS)
    ) checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run limit
    initial
    begin
        #5_000_000;
        $display("** xor_pair_parity_fec_sender: FAILED **");
        $finish;
    end

    // Sender idle cycles: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        if (src_steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    // Byte length that keeps the datagram
    function automatic logic [LEN_W-1:0] pick_kept_len();
        case ($urandom_range(0, 4))
            0:       return LEN_W'(MIN_BYTES);
            1:       return LEN_W'(2048);
            2:       return '1;
            3:       return LEN_W'($urandom_range(MIN_BYTES, 2048));
            default: return LEN_W'($urandom_range(MIN_BYTES, 4095));
        endcase
    endfunction

    // Payload content: all zeros, all ones, or random with stray extremes
    function automatic logic [WORD_W-1:0] payload_word(input int style);
        int r;
        if (style == 0)
            return '0;
        if (style == 1)
            return '1;
        r = $urandom_range(0, 15);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return $urandom;
    endfunction

    // One input beat; returns at the falling edge after it was taken
    task automatic send_beat(input logic [WORD_W-1:0] w, input logic is_first,
                             input logic [LEN_W-1:0] len);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, len, w};
        s_tuser  <= is_first;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
    endtask

    // Sequence beat followed by body_words beats of payload
    task automatic send_datagram(input logic [LEN_W-1:0] len, input logic [WORD_W-1:0] seq,
                                 input int body_words, input int style);
        send_beat(seq, 1'b1, len);
        for (int i = 0; i < body_words; i++)
            send_beat(payload_word(style), 1'b0, LEN_W'($urandom));
    endtask

    // Output side: random ready pattern, steady stretches, one long hold-off
    initial
    begin
        int   r;
        int   span;
        logic rdy;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_req)
            begin
                rdy      = 1'b0;
                span     = 400;
                hold_req = 1'b0;
            end
            else if (sink_steady)
            begin
                rdy  = 1'b1;
                span = 1;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 65)
                begin
                    rdy  = 1'b1;
                    span = $urandom_range(1, 8);
                end
                else if (r < 93)
                begin
                    rdy  = 1'b0;
                    span = $urandom_range(1, 3);
                end
                else
                begin
                    rdy  = 1'b0;
                    span = $urandom_range(10, 40);
                end
            end
            m_tready <= rdy;
            repeat (span) @(negedge clk);
        end
    end

    // Stimulus and verdict
    initial
    begin
        int r;
        int style;
        int body;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: stray words after reset, drops at the length edge, cut packets
        send_beat('0, 1'b0, '0);
        send_beat('1, 1'b0, '1);
        send_datagram(LEN_W'(MIN_BYTES - 1), 32'h0000_0003, 2, 2);
        send_datagram('0, '1, 1, 1);
        send_datagram('1, 32'h0000_0001, 5, 1);
        send_datagram(LEN_W'(MIN_BYTES), 32'h8000_0000, 0, 2);
        send_datagram(LEN_W'(2048), '0, 3, 0);

        // Random: mostly full datagrams, some cut, dropped or stray beats
        while (kept_beats < KEPT_TARGET)
        begin
            src_steady  = ($urandom_range(0, 3) == 0);
            sink_steady = ($urandom_range(0, 3) == 0);
            style = $urandom_range(0, 5);
            r     = $urandom_range(0, 99);
            if (!hold_issued && kept_beats >= 200)
            begin
                hold_req    = 1'b1;
                hold_issued = 1'b1;
                r           = 0;
            end
            if (r < 65)
            begin
                body = PAYLOAD_WORDS;
                if ($urandom_range(0, 3) == 0)
                    body += $urandom_range(1, 4);
                send_datagram(pick_kept_len(), $urandom, body, style);
                kept_beats += PAYLOAD_WORDS + 1;
            end
            else if (r < 78)
            begin
                body = $urandom_range(0, PAYLOAD_WORDS - 1);
                send_datagram(pick_kept_len(), $urandom, body, style);
                kept_beats += body + 1;
            end
            else if (r < 90)
            begin
                send_datagram(LEN_W'($urandom_range(0, MIN_BYTES - 1)), $urandom,
                              $urandom_range(0, 6), style);
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                    send_beat($urandom, 1'b0, LEN_W'($urandom));
            end
        end

        // Drain
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (50) @(negedge clk);

        if (fail_count == 0 && pending == 0)
        begin
            $display("** xor_pair_parity_fec_sender: PASSED **");
        end
        else
        begin
            $display("** xor_pair_parity_fec_sender: FAILED **");
        end
        $finish;
    end

endmodule
